@@ hdl/olae_pkg.sv @@
// ----------------------------------------------------------------------------
// olae_pkg
// Shared constants, codes and types of the ordered list array engine.
// ----------------------------------------------------------------------------
package olae_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int ST_W   = 2;
	localparam int CAP_W  = 5;
	localparam int KIND_W = 3;

	// command codes on the input port
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_EDIT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd5;

	// operation kinds after decode
	localparam logic [KIND_W-1:0] OP_NOP    = 3'd0;
	localparam logic [KIND_W-1:0] OP_APPEND = 3'd1;
	localparam logic [KIND_W-1:0] OP_INSERT = 3'd2;
	localparam logic [KIND_W-1:0] OP_EDIT   = 3'd3;
	localparam logic [KIND_W-1:0] OP_DELETE = 3'd4;
	localparam logic [KIND_W-1:0] OP_GET    = 3'd5;
	localparam logic [KIND_W-1:0] OP_SEARCH = 3'd6;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

	// configuration register addresses (word index)
	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] data;
	} op_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [DATA_W-1:0] read_value;
		logic [IDX_W-1:0]  found_index;
		logic [CNT_W-1:0]  entry_count;
		logic              list_empty;
		logic              is_full;
	} res_t;

endpackage

@@ hdl/olae_front.sv @@
// ----------------------------------------------------------------------------
// olae_front
// Accepts command words, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module olae_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [olae_pkg::CMD_W-1:0]   cmd,
	input  logic [olae_pkg::IDX_W-1:0]   index,
	input  logic signed [olae_pkg::DATA_W-1:0] data,
	output logic                         cq_valid,
	output olae_pkg::op_t                cq_item,
	input  logic                         cq_pop
);
	import olae_pkg::*;

	op_t         q_mem_q [2];
	logic        q_head_q;
	logic [1:0]  q_cnt_q;
	logic        wr_ptr;
	logic        do_push;
	logic        do_pop;
	op_t         op_in;

	always_comb begin
		op_in.index = index;
		op_in.data  = data;
		case (cmd)
			CMD_APPEND: op_in.kind = OP_APPEND;
			CMD_INSERT: op_in.kind = OP_INSERT;
			CMD_EDIT:   op_in.kind = OP_EDIT;
			CMD_DELETE: op_in.kind = OP_DELETE;
			CMD_GET:    op_in.kind = OP_GET;
			CMD_SEARCH: op_in.kind = OP_SEARCH;
			default:    op_in.kind = OP_NOP;
		endcase
	end

	assign full     = (q_cnt_q == 2'd2);
	assign do_push  = push && !full;
	assign do_pop   = cq_pop && cq_valid;
	assign wr_ptr   = q_head_q ^ q_cnt_q[0];
	assign cq_valid = (q_cnt_q != 2'd0);
	assign cq_item  = q_mem_q[q_head_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem_q[wr_ptr] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_head_q <= 1'b0;
			q_cnt_q  <= 2'd0;
		end else begin
			if (do_pop) begin
				q_head_q <= ~q_head_q;
			end
			case ({do_push, do_pop})
				2'b10:   q_cnt_q <= q_cnt_q + 2'd1;
				2'b01:   q_cnt_q <= q_cnt_q - 2'd1;
				default: q_cnt_q <= q_cnt_q;
			endcase
		end
	end

endmodule

@@ hdl/olae_back.sv @@
// ----------------------------------------------------------------------------
// olae_back
// Holds the list cells and the count, runs one command per cycle while the
// result queue has room, and queues the result words.
// ----------------------------------------------------------------------------
module olae_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cq_valid,
	input  olae_pkg::op_t                      cq_item,
	output logic                               cq_pop,
	input  logic [olae_pkg::CNT_W-1:0]         cap_eff,
	output logic                               empty,
	input  logic                               pop,
	output logic [olae_pkg::ST_W-1:0]          status,
	output logic signed [olae_pkg::DATA_W-1:0] read_value,
	output logic [olae_pkg::IDX_W-1:0]         found_index,
	output logic [olae_pkg::CNT_W-1:0]         entry_count,
	output logic                               list_empty,
	output logic                               is_full
);
	import olae_pkg::*;

	logic [DATA_W-1:0] ent_q [DEPTH];
	logic [DATA_W-1:0] ent_d [DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [CNT_W-1:0]  idx_c;
	logic              full_now;
	logic [DEPTH-1:0]  match;
	logic [IDX_W-1:0]  first_hit;
	logic              fire;
	res_t              res;

	res_t              r_mem_q [2];
	logic              r_head_q;
	logic [1:0]        r_cnt_q;
	logic              r_pop;

	assign idx_c    = {1'b0, cq_item.index};
	assign full_now = (count_q >= cap_eff);
	assign fire     = cq_valid && (r_cnt_q != 2'd2);
	assign cq_pop   = fire;

	// parallel compare against every live cell, lowest position wins
	always_comb begin
		first_hit = '0;
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = (CNT_W'(i) < count_q) && (ent_q[i] == cq_item.data);
		end
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				first_hit = IDX_W'(i);
			end
		end
	end

	always_comb begin
		ent_d           = ent_q;
		cnt_d           = count_q;
		res.status      = ST_OK;
		res.read_value  = '0;
		res.found_index = '0;
		case (cq_item.kind)
			OP_APPEND: begin
				if (full_now) begin
					res.status = ST_FULL;
				end else begin
					ent_d[count_q[IDX_W-1:0]] = cq_item.data;
					cnt_d = count_q + CNT_W'(1);
				end
			end
			OP_INSERT: begin
				if (idx_c > count_q) begin
					res.status = ST_BAD_INDEX;
				end else if (full_now) begin
					res.status = ST_FULL;
				end else begin
					for (int i = 1; i < DEPTH; i++) begin
						if (CNT_W'(i) > idx_c && CNT_W'(i) <= count_q) begin
							ent_d[i] = ent_q[i-1];
						end
					end
					ent_d[cq_item.index] = cq_item.data;
					cnt_d = count_q + CNT_W'(1);
				end
			end
			OP_EDIT: begin
				if (idx_c >= count_q) begin
					res.status = ST_BAD_INDEX;
				end else begin
					ent_d[cq_item.index] = cq_item.data;
				end
			end
			OP_DELETE: begin
				if (idx_c >= count_q) begin
					res.status = ST_BAD_INDEX;
				end else begin
					for (int i = 0; i < DEPTH - 1; i++) begin
						if (CNT_W'(i) >= idx_c && CNT_W'(i + 1) < count_q) begin
							ent_d[i] = ent_q[i+1];
						end
					end
					cnt_d = count_q - CNT_W'(1);
				end
			end
			OP_GET: begin
				if (idx_c >= count_q) begin
					res.status = ST_BAD_INDEX;
				end else begin
					res.read_value = ent_q[cq_item.index];
				end
			end
			OP_SEARCH: begin
				if (|match) begin
					res.found_index = first_hit;
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		res.entry_count = cnt_d;
		res.list_empty  = (cnt_d == '0);
		res.is_full     = (cnt_d >= cap_eff);
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ent_q <= ent_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= cnt_d;
		end
	end

	// result queue, two words deep
	assign empty = (r_cnt_q == 2'd0);
	assign r_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (fire) begin
			r_mem_q[r_head_q ^ r_cnt_q[0]] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_head_q <= 1'b0;
			r_cnt_q  <= 2'd0;
		end else begin
			if (r_pop) begin
				r_head_q <= ~r_head_q;
			end
			case ({fire, r_pop})
				2'b10:   r_cnt_q <= r_cnt_q + 2'd1;
				2'b01:   r_cnt_q <= r_cnt_q - 2'd1;
				default: r_cnt_q <= r_cnt_q;
			endcase
		end
	end

	assign status      = r_mem_q[r_head_q].status;
	assign read_value  = r_mem_q[r_head_q].read_value;
	assign found_index = r_mem_q[r_head_q].found_index;
	assign entry_count = r_mem_q[r_head_q].entry_count;
	assign list_empty  = r_mem_q[r_head_q].list_empty;
	assign is_full     = r_mem_q[r_head_q].is_full;

endmodule

@@ hdl/ordered_list_array_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_array_engine
// Fixed-capacity ordered list of signed words with queue-style command and
// result ports and an APB-style capacity register.
// ----------------------------------------------------------------------------
// Sustains one command word per cycle while the result queue has room:
// every list cell shifts, loads or compares in parallel, so the execute unit
// finishes any command combinationally. A pushed word is written into the
// command queue, executed from its head, and its result is registered into
// the result queue, where it shows on the result ports and can be popped.
// Command and result queues are two words deep each; full rises only when the
// result side has stalled long enough to back both up. The capacity register
// sits at byte address 0 (0 acts as 1, values above the depth act as the
// depth) and must only be written while no command is in flight. List cells
// hold no reset value; only positions below the count are ever read.
module ordered_list_array_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	// command side
	input  logic                               push,
	output logic                               full,
	input  logic [olae_pkg::CMD_W-1:0]         cmd,
	input  logic [olae_pkg::IDX_W-1:0]         index,
	input  logic signed [olae_pkg::DATA_W-1:0] data,
	// result side
	output logic                               empty,
	input  logic                               pop,
	output logic [olae_pkg::ST_W-1:0]          status,
	output logic signed [olae_pkg::DATA_W-1:0] read_value,
	output logic [olae_pkg::IDX_W-1:0]         found_index,
	output logic [olae_pkg::CNT_W-1:0]         entry_count,
	output logic                               list_empty,
	output logic                               is_full,
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import olae_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] cap_eff;
	logic             cfg_wr;
	logic             cq_valid;
	logic             cq_pop;
	op_t              cq_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(DEPTH);
		end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_q} : '0;

	// clamp capacity into 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (CNT_W'(cap_q) > CNT_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	olae_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.index    (index),
		.data     (data),
		.cq_valid (cq_valid),
		.cq_item  (cq_item),
		.cq_pop   (cq_pop)
	);

	olae_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cq_valid    (cq_valid),
		.cq_item     (cq_item),
		.cq_pop      (cq_pop),
		.cap_eff     (cap_eff),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.read_value  (read_value),
		.found_index (found_index),
		.entry_count (entry_count),
		.list_empty  (list_empty),
		.is_full     (is_full)
	);

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (entry_count <= CNT_W'(DEPTH)) && (list_empty == (entry_count == '0)))
		else $error("result word count out of range or empty flag wrong");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_FULL) |-> is_full)
		else $error("list full status without full flag");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !cq_valid && empty) |-> ##2 !empty)
		else $error("command word did not produce a result in two cycles");
`endif

endmodule
